@@ design/rbma_pkg.sv @@
`default_nettype none

package rbma_pkg;

   localparam int SAMPLE_W      = 16;
   localparam int WINDOW_REG_W  = 8;
   localparam int DEPTH_DEFAULT = 128;

   localparam logic [WINDOW_REG_W-1:0] WINDOW_RESET = WINDOW_REG_W'(1);

   typedef struct packed {
      logic capture;     // request taken, read old entry
      logic write_old;   // capture evicted sample, write new one, seed sum
      logic sum_step;    // walk one more stored sample of the window
      logic div_init;
      logic div_step;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic sum_done;
      logic div_done;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

@@ design/rbma_ctrl.sv @@
`default_nettype none

module rbma_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire rbma_pkg::status_type status,
   output rbma_pkg::cmd_type        cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_WRITE  = 3'd1;
   localparam logic [2:0] ST_SUM    = 3'd2;
   localparam logic [2:0] ST_DIVIDE = 3'd3;
   localparam logic [2:0] ST_DONE   = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_WRITE;
            end
         end
         ST_WRITE: begin
            cmd.write_old = 1'b1;
            state_in      = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum_step = 1'b1;
            if (status.sum_done) begin
               cmd.div_init = 1'b1;
               state_in     = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // hold the finished result until the output register is free
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

@@ design/rbma_datapath.sv @@
`default_nettype none

module rbma_datapath #(
   parameter int DEPTH = rbma_pkg::DEPTH_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire rbma_pkg::cmd_type                 cmd,
   output rbma_pkg::status_type                   status,
   input  wire logic [rbma_pkg::SAMPLE_W-1:0]     req_sample,
   input  wire logic                              csr_valid,
   input  wire logic [rbma_pkg::WINDOW_REG_W-1:0] csr_window_length,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [rbma_pkg::SAMPLE_W-1:0]          rsp_evicted_sample,
   output logic [rbma_pkg::SAMPLE_W-1:0]          rsp_average
);

   localparam int SW      = rbma_pkg::SAMPLE_W;
   localparam int MAX_WIN = (DEPTH < 255) ? DEPTH : 255;
   localparam int WIN_W   = $clog2(MAX_WIN + 1);
   localparam int SUM_W   = SW + WIN_W;
   localparam int CNT_W   = $clog2(SUM_W + 1);
   localparam int PTR_W   = $clog2(DEPTH);
   localparam int FILL_W  = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0]  LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [FILL_W-1:0] FULL     = FILL_W'(DEPTH);

   logic [SW-1:0] mem [DEPTH];
   logic [SW-1:0] rd_data_ff;
   logic [PTR_W-1:0] rd_addr;

   logic [rbma_pkg::WINDOW_REG_W-1:0] window_ff;
   logic [PTR_W-1:0]  pos_ff;
   logic [FILL_W-1:0] fill_ff;
   logic              take_ff;
   logic              rsp_valid_ff;

   logic [SW-1:0]     sample_ff;
   logic [SW-1:0]     evict_ff;
   logic [WIN_W-1:0]  win_ff;
   logic [WIN_W-1:0]  win_in;
   logic [WIN_W-1:0]  left_ff;
   logic [PTR_W-1:0]  idx_ff;
   logic              live_ff;
   logic [SUM_W-1:0]  acc_ff;
   logic [WIN_W-1:0]  rem_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [SW-1:0]     evicted_out_ff;
   logic [SW-1:0]     average_out_ff;

   logic [PTR_W-1:0]  pos_dec_in;
   logic [PTR_W-1:0]  idx_dec_in;
   logic [PTR_W-1:0]  pos_inc_in;
   logic [WIN_W:0]    trial_in;
   logic              fits_in;

   // zero means one, anything past the store depth means the whole store
   always_comb begin
      if (window_ff == '0) begin
         win_in = WIN_W'(1);
      end else if (32'(window_ff) > DEPTH) begin
         win_in = WIN_W'(DEPTH);
      end else begin
         win_in = WIN_W'(window_ff);
      end
   end

   assign pos_dec_in = (pos_ff == '0) ? LAST_PTR : pos_ff - PTR_W'(1);
   assign idx_dec_in = (idx_ff == '0) ? LAST_PTR : idx_ff - PTR_W'(1);
   assign pos_inc_in = (pos_ff == LAST_PTR) ? '0 : pos_ff + PTR_W'(1);
   assign rd_addr    = cmd.capture ? pos_ff : idx_ff;

   assign trial_in = {rem_ff, acc_ff[SUM_W-1]};
   assign fits_in  = (trial_in >= {1'b0, win_ff});

   assign status.sum_done = (left_ff == '0) && !take_ff;
   assign status.div_done = (cnt_ff == '0);
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_evicted_sample = evicted_out_ff;
   assign rsp_average        = average_out_ff;

   always_ff @(posedge clock) begin
      if (cmd.write_old) begin
         mem[pos_ff] <= sample_ff;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // entries at or above the fill count were never written and read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff    <= rbma_pkg::WINDOW_RESET;
         pos_ff       <= '0;
         fill_ff      <= '0;
         take_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            window_ff <= csr_window_length;
         end
         if (cmd.write_old) begin
            pos_ff <= pos_inc_in;
            if (fill_ff != FULL) begin
               fill_ff <= fill_ff + FILL_W'(1);
            end
         end
         if (cmd.sum_step) begin
            take_ff <= (left_ff != '0);
         end
         if (cmd.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         sample_ff <= req_sample;
         win_ff    <= win_in;
      end
      if (cmd.write_old) begin
         evict_ff <= (FILL_W'(pos_ff) < fill_ff) ? rd_data_ff : '0;
         acc_ff   <= SUM_W'(sample_ff);
         idx_ff   <= pos_dec_in;
         left_ff  <= win_ff - WIN_W'(1);
      end
      if (cmd.sum_step) begin
         if (left_ff != '0) begin
            left_ff <= left_ff - WIN_W'(1);
            idx_ff  <= idx_dec_in;
            live_ff <= (FILL_W'(idx_ff) < fill_ff);
         end
         if (take_ff && live_ff) begin
            acc_ff <= acc_ff + SUM_W'(rd_data_ff);
         end
      end
      if (cmd.div_init) begin
         rem_ff <= '0;
         cnt_ff <= CNT_W'(SUM_W);
      end
      // restoring divide, quotient bits shift into the sum register
      if (cmd.div_step && (cnt_ff != '0)) begin
         acc_ff <= {acc_ff[SUM_W-2:0], fits_in};
         rem_ff <= fits_in ? WIN_W'(trial_in - {1'b0, win_ff}) : WIN_W'(trial_in);
         cnt_ff <= cnt_ff - CNT_W'(1);
      end
      if (cmd.load_out) begin
         evicted_out_ff <= evict_ff;
         average_out_ff <= acc_ff[SW-1:0];
      end
   end

endmodule

`default_nettype wire

@@ design/ring_buffer_moving_average.sv @@
// Boxcar moving average over a circular store of DEPTH 16-bit samples.
// req channel: one sample per request. It is written at the write position,
// which then advances and wraps; the entry it overwrites is returned.
// rsp channel: rsp_evicted_sample (zero while that entry has not been written
// since reset) and rsp_average, the floor of the mean of the newest window
// samples, the new one included; unwritten entries count as zero.
// csr channel: window length, 8 bits, reset 1; zero acts as one and values
// above DEPTH act as DEPTH. csr_ready is always high; write only when idle.
// req_ready stays low from when a request is taken until its result is
// loaded into the output register, so one request is handled at a time. The
// sum register is SUM_W = 16 + bits of the largest window wide (24 at DEPTH
// 128). The result is presented in the cycle req_ready returns. The single
// memory read port walks the window one entry per cycle, then a
// one-bit-per-cycle divider runs.
// Results sit in an output register: the next request is accepted while a
// result waits; a stalled rsp_ready holds the following result back and
// keeps req_ready low until the output register drains.
// Reset is synchronous: window returns to 1, write position and fill count clear
// at once; no clearing pass, entries beyond the fill count read as zero.
`default_nettype none

module ring_buffer_moving_average #(
   parameter int DEPTH = rbma_pkg::DEPTH_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [rbma_pkg::SAMPLE_W-1:0]     req_sample,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [rbma_pkg::SAMPLE_W-1:0]          rsp_evicted_sample,
   output logic [rbma_pkg::SAMPLE_W-1:0]          rsp_average,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [rbma_pkg::WINDOW_REG_W-1:0] csr_window_length
);

   rbma_pkg::cmd_type    cmd;
   rbma_pkg::status_type status;

   assign csr_ready = 1'b1;

   rbma_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   rbma_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_sample         (req_sample),
      .csr_valid          (csr_valid),
      .csr_window_length  (csr_window_length),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_evicted_sample (rsp_evicted_sample),
      .rsp_average        (rsp_average)
   );

endmodule

`default_nettype wire

@@ design/rbma_checker.sv @@
`default_nettype none

module rbma_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_ready,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic [rbma_pkg::SAMPLE_W-1:0] rsp_average,
   input wire logic                          csr_ready
);

   // one request in flight: busy straight after taking one
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("req_ready high right after a request was taken");

   // a new result only appears coming out of the busy state, never from idle
   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared while the block was idle");

   a_csr_always_ready: assert property (@(posedge clock) disable iff (reset)
      csr_ready)
      else $error("csr_ready dropped");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_average)))
      else $error("stalled result changed or vanished");

endmodule

bind ring_buffer_moving_average rbma_checker u_rbma_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_average (rsp_average),
   .csr_ready   (csr_ready)
);

`default_nettype wire
